FILE: rtl/core/kdlp_pkg.sv
// ----------------------------------------------------------------------------
// kdlp_pkg: key debounce / long-press shared definitions
// Phase and event codes, reset thresholds and the scan state record.
// ----------------------------------------------------------------------------
package kdlp_pkg;

   localparam int unsigned TIME_W   = 32;
   localparam int unsigned THRESH_W = 16;
   localparam int unsigned EVENT_W  = 3;
   localparam int unsigned PHASE_W  = 2;

   // scan phases
   localparam logic [PHASE_W-1:0] PH_IDLE     = 2'd0;
   localparam logic [PHASE_W-1:0] PH_DEBOUNCE = 2'd1;
   localparam logic [PHASE_W-1:0] PH_PRESSED  = 2'd2;
   localparam logic [PHASE_W-1:0] PH_LONG     = 2'd3;

   // event codes
   localparam logic [EVENT_W-1:0] EV_NONE         = 3'd0;
   localparam logic [EVENT_W-1:0] EV_PRESS        = 3'd1;
   localparam logic [EVENT_W-1:0] EV_LONG_PRESS   = 3'd2;
   localparam logic [EVENT_W-1:0] EV_RELEASE      = 3'd3;
   localparam logic [EVENT_W-1:0] EV_LONG_RELEASE = 3'd4;

   // register indexes
   localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
   localparam logic [1:0] REG_LONG_PRESS = 2'd1;

   localparam logic [THRESH_W-1:0] DEBOUNCE_RESET   = 16'd20;
   localparam logic [THRESH_W-1:0] LONG_PRESS_RESET = 16'd2000;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic               ref_level;
      logic [TIME_W-1:0]  start;
   } kdlp_state_type;

endpackage

FILE: rtl/core/kdlp_step.sv
// ----------------------------------------------------------------------------
// kdlp_step: one scan step of the key machine
// Next phase, reference level, time stamp and event from one key sample.
// ----------------------------------------------------------------------------
module kdlp_step (
   input  kdlp_pkg::kdlp_state_type         cur,
   input  logic                             level,
   input  logic [kdlp_pkg::TIME_W-1:0]      now,
   input  logic [kdlp_pkg::THRESH_W-1:0]    debounce_time,
   input  logic [kdlp_pkg::THRESH_W-1:0]    long_press_time,
   output kdlp_pkg::kdlp_state_type         nxt,
   output logic [kdlp_pkg::EVENT_W-1:0]     event_res
);
   import kdlp_pkg::*;

   logic [TIME_W-1:0] elapsed;
   logic              differs;
   logic              debounce_over;
   logic              long_over;

   // modular difference, wraps with the tick counter
   assign elapsed       = now - cur.start;
   assign differs       = level != cur.ref_level;
   assign debounce_over = elapsed > {{(TIME_W-THRESH_W){1'b0}}, debounce_time};
   assign long_over     = elapsed > {{(TIME_W-THRESH_W){1'b0}}, long_press_time};

   always_comb begin
      nxt       = cur;
      event_res = EV_NONE;
      unique case (cur.phase)
         PH_IDLE: begin
            if (differs) begin
               nxt.phase = PH_DEBOUNCE;
               nxt.start = now;
            end
         end
         PH_DEBOUNCE: begin
            if (!differs) begin
               nxt.phase = PH_IDLE;
            end else if (debounce_over) begin
               nxt.phase = PH_PRESSED;
               nxt.start = now;
               event_res = EV_PRESS;
            end
         end
         PH_PRESSED: begin
            if (!differs) begin
               nxt.phase = PH_IDLE;
               event_res = EV_RELEASE;
            end else if (long_over) begin
               nxt.phase     = PH_LONG;
               nxt.ref_level = level;
               event_res     = EV_LONG_PRESS;
            end
         end
         default: begin
            if (differs) begin
               nxt.phase     = PH_IDLE;
               nxt.ref_level = level;
               event_res     = EV_LONG_RELEASE;
            end
         end
      endcase
   end

endmodule

FILE: rtl/core/key_debounce_long_press.sv
// ----------------------------------------------------------------------------
// key_debounce_long_press: key debounce and long-press detector
// Takes one key scan per request and returns one event per request.
// ----------------------------------------------------------------------------
//  channel | direction | payload                          | handshake
//  req     | in        | key_level, now                   | tvalid/tready
//  rsp     | out       | event_res                        | tvalid/tready
//  csr     | in        | debounce_time, long_press_time   | write enable
//
//  One request per cycle; the event appears in the output register on the
//  cycle after acceptance. Throughput is set by the single scan-state
//  register, updated at each accepted request.
//  A request is taken while the output register is empty or being drained.
//  Synchronous reset: idle phase, reference 0, thresholds 20 and 2000.
// ----------------------------------------------------------------------------
module key_debounce_long_press (
   input  logic        clock,
   input  logic        reset,
   // request: [0] key_level, [32:1] now, [39:33] zero
   input  logic [39:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // response: [2:0] event_res, [7:3] zero
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import kdlp_pkg::*;

   kdlp_state_type        state_ff;
   kdlp_state_type        state_in;
   logic [THRESH_W-1:0]   debounce_ff;
   logic [THRESH_W-1:0]   long_press_ff;
   logic [EVENT_W-1:0]    event_ff;
   logic [EVENT_W-1:0]    event_in;
   logic                  rsp_valid_ff;
   logic                  req_accept;

   // the output register frees up in the same cycle it is drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   kdlp_step u_step (
      .cur             (state_ff),
      .level           (req_tdata[0]),
      .now             (req_tdata[32:1]),
      .debounce_time   (debounce_ff),
      .long_press_time (long_press_ff),
      .nxt             (state_in),
      .event_res       (event_in)
   );

   // thresholds; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         long_press_ff <= LONG_PRESS_RESET;
      end else if (csr_we) begin
         if (csr_index == REG_DEBOUNCE) begin
            debounce_ff <= csr_wdata;
         end else if (csr_index == REG_LONG_PRESS) begin
            long_press_ff <= csr_wdata;
         end
      end
   end

   // scan state moves only on an accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase     <= PH_IDLE;
         state_ff.ref_level <= 1'b0;
         state_ff.start     <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // event payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         event_ff <= event_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(8-EVENT_W){1'b0}}, event_ff};

   // every accepted request leaves an event waiting
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid)
      else $error("no response after accepted request");

   // a long press always lands in the long-pressed phase
   a_long_phase: assert property (@(posedge clock) disable iff (reset)
      (req_accept && event_in == EV_LONG_PRESS) |=> (state_ff.phase == PH_LONG))
      else $error("long press without long-pressed phase");

   // the reference level only moves with a long press or long release
   a_ref_change: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && state_ff.ref_level != $past(state_ff.ref_level)) |->
      ($past(req_accept) && ($past(event_in) == EV_LONG_PRESS ||
                             $past(event_in) == EV_LONG_RELEASE)))
      else $error("reference level changed without long event");

   // a release event leaves the machine idle with the reference kept
   a_release_idle: assert property (@(posedge clock) disable iff (reset)
      (req_accept && event_in == EV_RELEASE) |=>
      (state_ff.phase == PH_IDLE && $stable(state_ff.ref_level)))
      else $error("release did not return to idle");

endmodule

FILE: bench/tb_key_debounce_long_press.sv
// ----------------------------------------------------------------------------
// tb_key_debounce_long_press: self-checking bench for the key debounce block
// Drives key scans (level plus time stamp) through the request stream. A
// scoreboard class predicts one event per accepted request and compares it
// with the response stream. Both sides idle at random. A long receiver
// hold-off makes the block stall its input. Thresholds change between phases.
// ----------------------------------------------------------------------------
module tb_key_debounce_long_press;
   import kdlp_pkg::*;

   // indexes past the register map: writes there must be ignored
   localparam logic [1:0] REG_SPARE_2 = 2'd2;
   localparam logic [1:0] REG_SPARE_3 = 2'd3;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int MAX_REPORTS     = 10;

   // ------------------------------------------------------------------------
   // Scoreboard: own copy of the scan state and thresholds, a queue of
   // predicted events in request order, and the failure count.
   // ------------------------------------------------------------------------
   class key_event_scoreboard;
      logic [PHASE_W-1:0]  phase;
      logic                ref_lvl;
      logic [TIME_W-1:0]   start;
      logic [THRESH_W-1:0] deb_time;
      logic [THRESH_W-1:0] lp_time;
      logic [EVENT_W-1:0]  predicted_events[$];
      int                  failures;
      int                  reported;

      function new();
         phase     = PH_IDLE;
         ref_lvl   = 1'b0;
         start     = '0;
         deb_time  = DEBOUNCE_RESET;
         lp_time   = LONG_PRESS_RESET;
         failures  = 0;
         reported  = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [THRESH_W-1:0] value);
         case (idx)
            REG_DEBOUNCE:   deb_time = value;
            REG_LONG_PRESS: lp_time  = value;
            default: ;
         endcase
      endfunction

      // next event of the four-phase machine; elapsed time is modular
      function logic [EVENT_W-1:0] next_event(logic level, logic [TIME_W-1:0] stamp);
         logic [TIME_W-1:0]  elapsed;
         logic               differs;
         logic [EVENT_W-1:0] ev;
         elapsed = stamp - start;
         differs = (level != ref_lvl);
         ev      = EV_NONE;
         case (phase)
            PH_IDLE: begin
               if (differs) begin
                  phase = PH_DEBOUNCE;
                  start = stamp;
               end
            end
            PH_DEBOUNCE: begin
               if (!differs) begin
                  phase = PH_IDLE;
               end else if (elapsed > TIME_W'(deb_time)) begin
                  ev    = EV_PRESS;
                  phase = PH_PRESSED;
                  start = stamp;
               end
            end
            PH_PRESSED: begin
               if (!differs) begin
                  phase = PH_IDLE;
                  ev    = EV_RELEASE;
               end else if (elapsed > TIME_W'(lp_time)) begin
                  ref_lvl = level;
                  ev      = EV_LONG_PRESS;
                  phase   = PH_LONG;
               end
            end
            default: begin
               if (differs) begin
                  ref_lvl = level;
                  phase   = PH_IDLE;
                  ev      = EV_LONG_RELEASE;
               end
            end
         endcase
         return ev;
      endfunction

      function void note_request(logic level, logic [TIME_W-1:0] stamp);
         predicted_events.push_back(next_event(level, stamp));
      endfunction

      function void check_response(logic [7:0] data);
         logic [7:0] want;
         if (predicted_events.size() == 0) begin
            failures++;
            if (reported < MAX_REPORTS) begin
               reported++;
               $display("ERROR: response %0h with no request outstanding", data);
            end
            return;
         end
         want = {5'd0, predicted_events.pop_front()};
         if (data !== want) begin
            failures++;
            if (reported < MAX_REPORTS) begin
               reported++;
               $display("ERROR: event mismatch: expected %0d, got %0d (raw %0h)",
                        want[EVENT_W-1:0], data[EVENT_W-1:0], data);
            end
         end
      endfunction

      function int outstanding();
         return predicted_events.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // DUT signals; every input is known from time zero
   // ------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic [39:0] req_tdata  = '0;   // [0] key_level, [32:1] now, [39:33] zero
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  rsp_tdata;         // [2:0] event_res, [7:3] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = '0;
   logic [15:0] csr_wdata  = '0;

   key_event_scoreboard sb;
   bit                  burst;              // no idling on either side
   bit                  hold_off_request;   // ask the receiver for a long stall
   logic [TIME_W-1:0]   scan_time;          // bench's time stamp for key scans

   key_debounce_long_press uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // a step that lands just below, on, or just past a threshold
   function automatic logic [TIME_W-1:0] near_threshold(logic [THRESH_W-1:0] th);
      return TIME_W'(th) + TIME_W'($urandom_range(0, 3)) - 1;
   endfunction

   // ------------------------------------------------------------------------
   // Request side. Valid stays high across back-to-back requests; it is
   // only dropped when a gap is wanted, so one NBA per step.
   // ------------------------------------------------------------------------
   task automatic send_scan(input logic level, input logic [TIME_W-1:0] stamp);
      int gap;
      gap = burst ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {7'd0, stamp, level};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(level, stamp);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   // wait for every predicted event, then let the output stage settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Random press episodes: optional contact bounce, a hold that straddles
   // the debounce threshold, then either an early release or a hold past
   // the long-press threshold and a long release. Some pure noise mixed in.
   // ------------------------------------------------------------------------
   task automatic random_presses(input int count);
      int   sent;
      logic tgt;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 3) == 0) scan_time = $urandom;
         if ($urandom_range(0, 9) == 0) begin
            // noise: any level at any stamp
            send_scan(1'($urandom_range(0, 1)), $urandom);
            sent++;
         end else begin
            tgt = ~sb.ref_lvl;
            // idle scans at the reference level
            repeat ($urandom_range(0, 1)) begin
               scan_time += $urandom_range(0, 7);
               send_scan(~tgt, scan_time);
               sent++;
            end
            // contact bounce
            repeat ($urandom_range(0, 2)) begin
               send_scan(tgt, scan_time);
               scan_time += $urandom_range(0, 3);
               send_scan(~tgt, scan_time);
               scan_time += 1;
               sent += 2;
            end
            send_scan(tgt, scan_time);
            scan_time += near_threshold(sb.deb_time);
            send_scan(tgt, scan_time);
            sent += 2;
            repeat ($urandom_range(0, 2)) begin
               scan_time += $urandom_range(0, 3);
               send_scan(tgt, scan_time);
               sent++;
            end
            if ($urandom_range(0, 2) == 0) begin
               // early release
               scan_time += $urandom_range(0, 5);
               send_scan(~tgt, scan_time);
               sent++;
            end else begin
               scan_time += near_threshold(sb.lp_time);
               send_scan(tgt, scan_time);
               scan_time += $urandom_range(0, 100);
               send_scan(tgt, scan_time);
               scan_time += $urandom_range(0, 50);
               send_scan(~tgt, scan_time);
               sent += 3;
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side: checks on each handshake, stalls at random, and honours
   // one long hold-off on request. One NBA on rsp_tready per edge.
   // ------------------------------------------------------------------------
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (hold_off_request) begin
            stall_left       = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!burst && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      logic              tgt;
      logic [TIME_W-1:0] t0;
      sb               = new();
      burst            = 1'b0;
      hold_off_request = 1'b0;
      scan_time        = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // phase 1: reset thresholds (20 / 2000), reference low
      send_scan(1'b0, 32'd100);          // idle, level at reference
      send_scan(1'b1, 32'd100);          // start debounce
      send_scan(1'b1, 32'd120);          // elapsed equals threshold: no press
      send_scan(1'b1, 32'd121);          // press
      send_scan(1'b0, 32'd130);          // release before long press
      send_scan(1'b1, 32'd200);
      send_scan(1'b0, 32'd205);          // bounce back to idle
      send_scan(1'b1, 32'd300);
      send_scan(1'b1, 32'd400);          // press
      send_scan(1'b1, 32'd2400);         // exactly long-press time: nothing
      send_scan(1'b1, 32'd2401);         // long press, reference goes high
      send_scan(1'b1, 32'd3000);         // held: nothing
      send_scan(1'b0, 32'd3001);         // long release
      send_scan(1'b1, 32'hFFFF_FFF0);    // debounce across the counter wrap
      send_scan(1'b1, 32'h0000_0005);    // elapsed 21 through the wrap: press
      send_scan(1'b0, 32'hFFFF_FFFF);    // release
      random_presses(60);
      drain();

      // phase 2: zero thresholds, any nonzero elapsed time qualifies
      csr_write(REG_DEBOUNCE, 16'd0);
      csr_write(REG_LONG_PRESS, 16'd0);
      csr_we <= 1'b0;
      tgt = ~sb.ref_lvl;
      send_scan(tgt, 32'hFFFF_FFFF);
      send_scan(tgt, 32'hFFFF_FFFF);     // elapsed zero: no press
      send_scan(tgt, 32'h0000_0000);     // press
      send_scan(tgt, 32'h0000_0000);     // elapsed zero: no long press
      send_scan(tgt, 32'h0000_0001);     // long press
      send_scan(~tgt, 32'h0000_0001);    // long release
      random_presses(60);
      drain();

      // phase 3: largest thresholds
      csr_write(REG_DEBOUNCE, 16'hFFFF);
      csr_write(REG_LONG_PRESS, 16'hFFFF);
      csr_we <= 1'b0;
      tgt = ~sb.ref_lvl;
      t0  = 32'h8000_0000;
      send_scan(tgt, t0);
      send_scan(tgt, t0 + 32'd65535);
      send_scan(tgt, t0 + 32'd65536);    // press
      send_scan(tgt, t0 + 32'd131071);
      send_scan(tgt, t0 + 32'd131072);   // long press
      send_scan(~tgt, t0 + 32'd131073);  // long release
      random_presses(60);
      drain();

      // phase 4: spare indexes must not disturb the thresholds; the receiver
      // holds off while the sender keeps pushing, so the input stalls
      csr_write(REG_SPARE_2, 16'($urandom_range(0, 65535)));
      csr_write(REG_SPARE_3, 16'($urandom_range(0, 65535)));
      csr_write(REG_DEBOUNCE, 16'($urandom_range(0, 40)));
      csr_write(REG_LONG_PRESS, 16'($urandom_range(0, 300)));
      csr_write(REG_SPARE_3, 16'hFFFF);
      csr_we           <= 1'b0;
      burst            = 1'b1;
      hold_off_request = 1'b1;
      random_presses(80);
      drain();

      // phase 5: random thresholds over the full range, no idling at all
      csr_write(REG_DEBOUNCE, 16'($urandom_range(0, 65535)));
      csr_write(REG_LONG_PRESS, 16'($urandom_range(0, 65535)));
      csr_we <= 1'b0;
      random_presses(60);
      drain();

      // phase 6: back to the reset thresholds, random idling again
      burst = 1'b0;
      csr_write(REG_DEBOUNCE, DEBOUNCE_RESET);
      csr_write(REG_LONG_PRESS, LONG_PRESS_RESET);
      csr_we <= 1'b0;
      random_presses(60);
      drain();

      repeat (10) @(posedge clock);
      if (sb.failures == 0 && sb.outstanding() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog, well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
